// ----- design/mcdp_pkg.sv -----
// Package: phase codes, chunk tags, fault codes and header-check table.
`default_nettype none
package mcdp_pkg;
    localparam logic [1:0] PH_HEAD = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_SKIP = 2'd2;

    localparam logic [31:0] TAG_FILEHDR = 32'h3356_5848;
    localparam logic [31:0] TAG_VIDEO   = 32'h5646_524d;
    localparam logic [31:0] TAG_AUDIO   = 32'h4155_4430;

    localparam logic [2:0] F_OK     = 3'd0;
    localparam logic [2:0] F_SIZE   = 3'd1;
    localparam logic [2:0] F_KNOWN  = 3'd2;
    localparam logic [2:0] F_DUP    = 3'd3;
    localparam logic [2:0] F_HDRVAL = 3'd4;
    localparam logic [2:0] F_VIDEO  = 3'd5;
    localparam logic [2:0] F_AUDIO  = 3'd6;

    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_VIDEO = 2'd1;
    localparam logic [1:0] K_AUDIO = 2'd2;

    localparam logic [18:0] MAX_FRAMES = 19'd450000;

    typedef struct packed {
        logic       chk;
        logic [7:0] val;
    } t_expect;

    // Expected file-header byte at a chunk position.
    function automatic t_expect expected_byte(input logic [5:0] pos);
        t_expect e;
        e.chk = 1'b1;
        e.val = 8'h00;
        case (pos)
            6'd16: e.val = 8'h00;  6'd17: e.val = 8'h01;
            6'd18: e.val = 8'h00;  6'd19: e.val = 8'h40;
            6'd20: e.val = 8'h01;  6'd21: e.val = 8'h40;
            6'd22: e.val = 8'h00;  6'd23: e.val = 8'hf0;
            6'd24: e.val = 8'h00;  6'd25: e.val = 8'h00;
            6'd26: e.val = 8'h75;  6'd27: e.val = 8'h30;
            6'd28: e.val = 8'h00;  6'd29: e.val = 8'h00;
            6'd30: e.val = 8'h03;  6'd31: e.val = 8'he9;
            6'd32: e.val = 8'h00;
            6'd36: e.val = 8'h00;  6'd37: e.val = 8'h00;
            6'd38: e.val = 8'h56;  6'd39: e.val = 8'h22;
            6'd40: e.val = 8'h00;  6'd41: e.val = 8'h02;
            6'd42: e.val = 8'h53;  6'd43: e.val = 8'h32;
            6'd44: e.val = 8'h00;  6'd45: e.val = 8'h00;
            6'd46: e.val = 8'hac;  6'd47: e.val = 8'h44;
            default: e.chk = 1'b0;
        endcase
        return e;
    endfunction
endpackage
`default_nettype wire

// ----- design/media_chunk_demux_parser_core.sv -----
// Top level: byte-serial container chunk parser and payload demux.
//
//  channel | direction | handshake             | word
//  in      | input     | i_in_valid/o_in_stall | stream byte + rewind
//  out     | output    | o_out_valid/i_out_stall| one result per byte
//  cfg     | input     | i_cfg_valid/o_cfg_ready| file_length
//
// One byte per cycle while the sink does not stall: the parser state updates in the cycle
// the byte is accepted and its result lands in a single output register.
// Input is stalled only while that register holds a word the sink stalls.
// Reset is synchronous, active low; it clears parser state and file_length.
// The result is valid in the cycle after the byte is accepted.
`default_nettype none
module media_chunk_demux_parser_core #(
    parameter int WINDOW_BYTES     = 65536,
    parameter int FRAME_MAX_BYTES  = 32768,
    parameter int AUDIO_RING_BYTES = 16384
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_stream_byte,
    input  wire         i_rewind,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_payload_kind,
    output logic [7:0]  o_payload_byte,
    output logic [18:0] o_frame_number,
    output logic        o_last_of_payload,
    output logic        o_header_seen,
    output logic [2:0]  o_fault_code,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [31:0] i_cfg_data
);
    // size fields hold sizes up to WINDOW_BYTES; 17 bits covers the range
    localparam int LW = $clog2(WINDOW_BYTES + 1);
    localparam logic [31:0] WIN  = 32'(WINDOW_BYTES);
    localparam logic [31:0] VMAX = 32'(FRAME_MAX_BYTES + 16);
    localparam logic [31:0] AMAX = 32'(AUDIO_RING_BYTES + 20);
    localparam logic [31:0] AHALF = 32'(AUDIO_RING_BYTES / 2);

    logic [31:0] r_file_length;
    logic [1:0]  r_phase, n_phase;
    logic [LW-1:0] r_pos, n_pos;
    logic [31:0] r_offset, n_offset;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_len, n_len;     // full size word from header
    logic [31:0] r_time, n_time;
    logic        r_hchk, n_hchk;
    logic [18:0] r_total, n_total;
    logic [18:0] r_frames, n_frames;
    logic [31:0] r_abytes, n_abytes;
    logic [31:0] r_acount, n_acount;
    logic        r_have, n_have;
    logic [2:0]  r_fault, n_fault;

    logic        r_ov;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_obyte, n_obyte;
    logic [18:0] r_fnum, n_fnum;
    logic        r_last, n_last;

    logic accept;
    assign o_in_stall  = r_ov & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    mcdp_pkg::t_expect ex;
    logic [31:0] start, left, npos32, stop, room, mx_len;
    logic [7:0] b;

    always_comb begin
        b = i_stream_byte;
        n_phase = r_phase; n_pos = r_pos; n_offset = r_offset; n_tag = r_tag;
        n_len = r_len; n_time = r_time; n_hchk = r_hchk; n_total = r_total;
        n_frames = r_frames; n_abytes = r_abytes; n_acount = r_acount;
        n_have = r_have; n_fault = r_fault;
        n_kind = mcdp_pkg::K_NONE; n_obyte = 8'd0; n_fnum = 19'd0; n_last = 1'b0;
        ex = mcdp_pkg::expected_byte(r_pos[5:0]);
        npos32 = 32'(r_pos) + 32'd1;
        start = r_offset - 32'd15;
        left = (r_file_length >= start) ? r_file_length - start : 32'd0;
        stop = 32'd20 + {r_acount[30:0], 1'b0};
        mx_len = {r_len[23:0], b};
        room = (r_len - 32'd20) >> 1;
        if (i_rewind) begin
            n_phase = mcdp_pkg::PH_HEAD; n_pos = '0; n_offset = '0; n_tag = '0;
            n_len = '0; n_time = '0; n_hchk = 1'b1; n_total = '0; n_frames = '0;
            n_abytes = '0; n_acount = '0; n_have = 1'b0; n_fault = mcdp_pkg::F_OK;
        end else if (r_fault == mcdp_pkg::F_OK) begin
            n_offset = r_offset + 32'd1;
            case (r_phase)
                mcdp_pkg::PH_HEAD: begin
                    if (r_pos < LW'(4)) n_tag = {r_tag[23:0], b};
                    else if (r_pos < LW'(8)) n_len = mx_len;
                    else if (r_pos < LW'(12)) n_time = {r_time[23:0], b};
                    n_pos = r_pos + LW'(1);
                    if (r_pos >= LW'(15)) begin
                        if (r_len < 32'd16 || r_len > WIN || r_len[1:0] != 2'd0
                            || r_len > left) begin
                            n_fault = mcdp_pkg::F_SIZE;
                        end else if (r_tag != mcdp_pkg::TAG_FILEHDR
                            && r_tag != mcdp_pkg::TAG_VIDEO
                            && r_tag != mcdp_pkg::TAG_AUDIO) begin
                            if (r_len == 32'd16) begin
                                n_phase = mcdp_pkg::PH_HEAD; n_pos = '0;
                            end else begin
                                n_phase = mcdp_pkg::PH_SKIP; n_pos = LW'(16);
                            end
                        end else if ((r_tag == mcdp_pkg::TAG_FILEHDR && r_len != 32'd80)
                            || (r_tag == mcdp_pkg::TAG_VIDEO && r_len > VMAX)
                            || (r_tag == mcdp_pkg::TAG_AUDIO && r_len > AMAX)) begin
                            n_fault = mcdp_pkg::F_KNOWN;
                        end else if (r_tag == mcdp_pkg::TAG_FILEHDR) begin
                            if (r_have) n_fault = mcdp_pkg::F_DUP;
                            else begin
                                n_hchk = 1'b1; n_total = '0;
                                n_phase = mcdp_pkg::PH_BODY; n_pos = LW'(16);
                            end
                        end else if (r_tag == mcdp_pkg::TAG_VIDEO) begin
                            if (!r_have || r_len < 32'd20 || r_time != 32'(r_frames)
                                || r_time >= 32'(r_total))
                                n_fault = mcdp_pkg::F_VIDEO;
                            else begin
                                n_phase = mcdp_pkg::PH_BODY; n_pos = LW'(16);
                            end
                        end else begin
                            if (r_len < 32'd20 || !r_have || r_time != (r_abytes >> 1))
                                n_fault = mcdp_pkg::F_AUDIO;
                            else begin
                                n_acount = '0;
                                n_phase = mcdp_pkg::PH_BODY; n_pos = LW'(16);
                            end
                        end
                    end
                end
                mcdp_pkg::PH_SKIP: begin
                    n_pos = r_pos + LW'(1);
                    if (npos32 >= r_len) begin
                        n_phase = mcdp_pkg::PH_HEAD; n_pos = '0;
                    end
                end
                default: begin
                    n_pos = r_pos + LW'(1);
                    if (r_tag == mcdp_pkg::TAG_FILEHDR) begin
                        if (ex.chk) begin
                            if (b != ex.val) n_hchk = 1'b0;
                        end else if (r_pos == LW'(33)) begin
                            if (b >= 8'd8) n_hchk = 1'b0;
                            n_total = {16'd0, b[2:0]};
                        end else if (r_pos == LW'(34) || r_pos == LW'(35)) begin
                            n_total = {r_total[10:0], b};
                        end
                        if (npos32 >= r_len) begin
                            if (r_hchk && (!ex.chk || b == ex.val) && n_total != 19'd0
                                && n_total <= mcdp_pkg::MAX_FRAMES) begin
                                n_have = 1'b1;
                                n_phase = mcdp_pkg::PH_HEAD; n_pos = '0;
                            end else n_fault = mcdp_pkg::F_HDRVAL;
                        end
                    end else if (r_tag == mcdp_pkg::TAG_VIDEO) begin
                        n_kind = mcdp_pkg::K_VIDEO; n_obyte = b; n_fnum = r_time[18:0];
                        if (npos32 >= r_len) begin
                            n_last = 1'b1; n_frames = r_frames + 19'd1;
                            n_phase = mcdp_pkg::PH_HEAD; n_pos = '0;
                        end
                    end else begin
                        if (r_pos < LW'(20)) begin
                            n_acount = {r_acount[23:0], b};
                            if (r_pos == LW'(19)
                                && (n_acount > room || n_acount > AHALF))
                                n_fault = mcdp_pkg::F_AUDIO;
                        end else if (32'(r_pos) < stop) begin
                            n_kind = mcdp_pkg::K_AUDIO; n_obyte = b;
                            if (npos32 == stop) begin
                                n_last = 1'b1;
                                n_abytes = r_abytes + {r_acount[30:0], 1'b0};
                            end
                        end
                        if (n_fault == mcdp_pkg::F_OK && npos32 >= r_len) begin
                            n_phase = mcdp_pkg::PH_HEAD; n_pos = '0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_length <= '0;
            r_phase <= mcdp_pkg::PH_HEAD; r_pos <= '0; r_offset <= '0; r_tag <= '0;
            r_len <= '0; r_time <= '0; r_hchk <= 1'b1; r_total <= '0; r_frames <= '0;
            r_abytes <= '0; r_acount <= '0; r_have <= 1'b0; r_fault <= mcdp_pkg::F_OK;
            r_ov <= 1'b0;
        end else begin
            if (i_cfg_valid) r_file_length <= i_cfg_data;
            if (accept) begin
                r_phase <= n_phase; r_pos <= n_pos; r_offset <= n_offset; r_tag <= n_tag;
                r_len <= n_len; r_time <= n_time; r_hchk <= n_hchk; r_total <= n_total;
                r_frames <= n_frames; r_abytes <= n_abytes; r_acount <= n_acount;
                r_have <= n_have; r_fault <= n_fault;
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= n_kind; r_obyte <= n_obyte; r_fnum <= n_fnum; r_last <= n_last;
        end
    end

    assign o_out_valid       = r_ov;
    assign o_payload_kind    = r_kind;
    assign o_payload_byte    = r_obyte;
    assign o_frame_number    = r_fnum;
    assign o_last_of_payload = r_last;
    assign o_header_seen     = r_have;
    assign o_fault_code      = r_fault;

    // a wedged parser delivers nothing
    a_wedge_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fault != mcdp_pkg::F_OK && accept && !i_rewind) |=> r_kind == mcdp_pkg::K_NONE)
        else $error("payload delivered while wedged");
    // last flag only with a payload byte
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_last) |-> r_kind != mcdp_pkg::K_NONE)
        else $error("last without payload");
    // rewind clears fault and header flag
    a_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_rewind) |=> (r_fault == mcdp_pkg::F_OK && !r_have))
        else $error("rewind did not clear state");
endmodule
`default_nettype wire

// ----- bench/mcdp_checker.sv -----
// Checker: watches the config, input and output channels, predicts each result word and compares.
`default_nettype none
module mcdp_checker #(
    parameter int WINDOW_BYTES     = 65536,
    parameter int FRAME_MAX_BYTES  = 32768,
    parameter int AUDIO_RING_BYTES = 16384
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  wire  [7:0]  i_stream_byte,
    input  wire         i_rewind,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire  [1:0]  i_payload_kind,
    input  wire  [7:0]  i_payload_byte,
    input  wire  [18:0] i_frame_number,
    input  wire         i_last_of_payload,
    input  wire         i_header_seen,
    input  wire  [2:0]  i_fault_code,
    input  wire         i_cfg_valid,
    input  wire         i_cfg_ready,
    input  wire  [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [18:0] frame;
        logic        last;
        logic        hdr;
        logic [2:0]  fault;
    } t_word;

    // header body image, chunk positions 16..47; 32..35 hold the frame count
    localparam logic [255:0] HDR_IMAGE = {16'd1, 16'd64, 16'd320, 16'd240, 32'd30000,
        32'd1001, 32'd0, 32'd22050, 16'd2, 16'h5332, 32'd44100};

    t_word       expected_q[$];
    logic [31:0] file_len;
    logic [1:0]  phase;
    logic [31:0] pos_r, offset_r, tag_r, len_r, time_r;
    logic        fields_ok;
    logic [18:0] frames_total, frames_done;
    logic [31:0] audio_done, sample_cnt;
    logic        hdr_ok;
    logic [2:0]  fault_r;

    function automatic void clear_parser();
        phase = mcdp_pkg::PH_HEAD; pos_r = 0; offset_r = 0; tag_r = 0; len_r = 0;
        time_r = 0; fields_ok = 1'b1; frames_total = 0; frames_done = 0; audio_done = 0;
        sample_cnt = 0; hdr_ok = 1'b0; fault_r = mcdp_pkg::F_OK;
    endfunction

    // end of the 16-byte chunk header: bounds, then per-tag admission
    function automatic void close_chunk_header();
        logic [31:0] start, left;
        start = offset_r - 32'd15;
        left  = (file_len >= start) ? file_len - start : 32'd0;
        if (len_r < 16 || len_r > WINDOW_BYTES || len_r[1:0] != 2'b00 || len_r > left) begin
            fault_r = mcdp_pkg::F_SIZE;
        end else if (tag_r != mcdp_pkg::TAG_FILEHDR && tag_r != mcdp_pkg::TAG_VIDEO
                && tag_r != mcdp_pkg::TAG_AUDIO) begin
            if (len_r == 16) begin
                phase = mcdp_pkg::PH_HEAD; pos_r = 0;
            end else begin
                phase = mcdp_pkg::PH_SKIP; pos_r = 16;
            end
        end else if ((tag_r == mcdp_pkg::TAG_FILEHDR && len_r != 80)
                || (tag_r == mcdp_pkg::TAG_VIDEO && len_r > FRAME_MAX_BYTES + 16)
                || (tag_r == mcdp_pkg::TAG_AUDIO && len_r > AUDIO_RING_BYTES + 20)) begin
            fault_r = mcdp_pkg::F_KNOWN;
        end else if (tag_r == mcdp_pkg::TAG_FILEHDR && hdr_ok) begin
            fault_r = mcdp_pkg::F_DUP;
        end else if (tag_r == mcdp_pkg::TAG_VIDEO && (!hdr_ok || len_r < 20
                || time_r != {13'd0, frames_done} || time_r >= {13'd0, frames_total})) begin
            fault_r = mcdp_pkg::F_VIDEO;
        end else if (tag_r == mcdp_pkg::TAG_AUDIO && (len_r < 20 || !hdr_ok
                || time_r != audio_done / 2)) begin
            fault_r = mcdp_pkg::F_AUDIO;
        end else begin
            if (tag_r == mcdp_pkg::TAG_FILEHDR) begin
                fields_ok = 1'b1; frames_total = 0;
            end
            if (tag_r == mcdp_pkg::TAG_AUDIO) sample_cnt = 0;
            phase = mcdp_pkg::PH_BODY; pos_r = 16;
        end
    endfunction

    function automatic t_word parse_byte(input logic [7:0] b, input logic rw);
        t_word w;
        logic [31:0] p, stop;
        w = '0;
        if (rw) begin
            clear_parser();
        end else if (fault_r == mcdp_pkg::F_OK) begin
            p = pos_r;
            if (phase == mcdp_pkg::PH_HEAD) begin
                if (p < 4) tag_r = {tag_r[23:0], b};
                else if (p < 8) len_r = {len_r[23:0], b};
                else if (p < 12) time_r = {time_r[23:0], b};
                pos_r = p + 1;
                if (p >= 15) close_chunk_header();
            end else if (phase == mcdp_pkg::PH_SKIP) begin
                pos_r = p + 1;
                if (pos_r >= len_r) begin
                    phase = mcdp_pkg::PH_HEAD; pos_r = 0;
                end
            end else if (tag_r == mcdp_pkg::TAG_FILEHDR) begin
                if ((p >= 16 && p < 32) || (p >= 36 && p < 48)) begin
                    if (b != HDR_IMAGE[255 - 8*(p-16) -: 8]) fields_ok = 1'b0;
                end else if (p == 32) begin
                    if (b != 0) fields_ok = 1'b0;
                end else if (p == 33) begin
                    if (b >= 8) fields_ok = 1'b0;
                    frames_total = {16'd0, b[2:0]};
                end else if (p == 34 || p == 35) begin
                    frames_total = {frames_total[10:0], b};
                end
                pos_r = p + 1;
                if (pos_r >= len_r) begin
                    if (fields_ok && frames_total != 0
                            && frames_total <= mcdp_pkg::MAX_FRAMES) begin
                        hdr_ok = 1'b1; phase = mcdp_pkg::PH_HEAD; pos_r = 0;
                    end else begin
                        fault_r = mcdp_pkg::F_HDRVAL;
                    end
                end
            end else if (tag_r == mcdp_pkg::TAG_VIDEO) begin
                w.kind = mcdp_pkg::K_VIDEO; w.data = b; w.frame = time_r[18:0];
                pos_r = p + 1;
                if (pos_r >= len_r) begin
                    w.last = 1'b1; frames_done = frames_done + 1'b1;
                    phase = mcdp_pkg::PH_HEAD; pos_r = 0;
                end
            end else begin
                if (p < 20) begin
                    sample_cnt = {sample_cnt[23:0], b};
                    if (p == 19 && (sample_cnt > (len_r - 20) / 2
                            || sample_cnt > AUDIO_RING_BYTES / 2))
                        fault_r = mcdp_pkg::F_AUDIO;
                end else begin
                    stop = 20 + 2 * sample_cnt;
                    if (p < stop) begin
                        w.kind = mcdp_pkg::K_AUDIO; w.data = b;
                        if (p + 1 == stop) begin
                            w.last = 1'b1; audio_done = audio_done + 2 * sample_cnt;
                        end
                    end
                end
                pos_r = p + 1;
                if (fault_r == mcdp_pkg::F_OK && pos_r >= len_r) begin
                    phase = mcdp_pkg::PH_HEAD; pos_r = 0;
                end
            end
            offset_r = offset_r + 1;
        end
        w.hdr = hdr_ok;
        w.fault = fault_r;
        return w;
    endfunction

    t_word got, want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            file_len = 0;
            clear_parser();
            expected_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) file_len = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                got = {i_payload_kind, i_payload_byte, i_frame_number, i_last_of_payload,
                       i_header_seen, i_fault_code};
                if (expected_q.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10) $display("unexpected word %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got != want) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10)
                            $display({"word error: kind %0d/%0d byte %h/%h frame %0d/%0d",
                                " last %0d/%0d hdr %0d/%0d fault %0d/%0d (exp/got)"},
                                want.kind, got.kind, want.data, got.data, want.frame,
                                got.frame, want.last, got.last, want.hdr, got.hdr,
                                want.fault, got.fault);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(parse_byte(i_stream_byte, i_rewind));
        end
        o_pending = expected_q.size();
    end
endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench top: clock, reset, file stimulus, sink stalls, watchdog and verdict.
`default_nettype none
module tb_top;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [255:0] HDR_IMAGE = {16'd1, 16'd64, 16'd320, 16'd240, 32'd30000,
        32'd1001, 32'd0, 32'd22050, 16'd2, 16'h5332, 32'd44100};

    // ways a chunk can be broken on purpose
    typedef enum int {
        BRK_NONE, BRK_ALIGN, BRK_TINY, BRK_HUGE, BRK_VID_TIME, BRK_AUD_TIME,
        BRK_AUD_COUNT, BRK_HDR_FIELD, BRK_HDR_SIZE, BRK_DUP_HDR, BRK_ZERO_FRAMES,
        BRK_VID_BIG, BRK_OVERRUN
    } t_break;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_stream_byte = 8'd0;
    logic        i_rewind = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [31:0] i_cfg_data = 32'd0;
    wire         o_in_stall, o_out_valid, o_last_of_payload, o_header_seen, o_cfg_ready;
    wire  [1:0]  o_payload_kind;
    wire  [7:0]  o_payload_byte;
    wire  [18:0] o_frame_number;
    wire  [2:0]  o_fault_code;
    int          fail_count, pending;

    always #5 i_clk = ~i_clk;

    media_chunk_demux_parser_core dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_stream_byte, .i_rewind,
        .o_out_valid, .i_out_stall, .o_payload_kind, .o_payload_byte, .o_frame_number,
        .o_last_of_payload, .o_header_seen, .o_fault_code, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_data
    );

    mcdp_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_stream_byte, .i_rewind,
        .i_out_valid(o_out_valid), .i_out_stall, .i_payload_kind(o_payload_kind),
        .i_payload_byte(o_payload_byte), .i_frame_number(o_frame_number),
        .i_last_of_payload(o_last_of_payload), .i_header_seen(o_header_seen),
        .i_fault_code(o_fault_code), .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // ---------------- sink side: per-word stall draw plus one long hold-off ----------------
    int  sink_gap = 0;
    bit  sink_hold_on = 1'b0;
    bit  sink_calm = 1'b0;
    int  bytes_sent = 0;

    always @(negedge i_clk) begin
        if (sink_hold_on) begin
            i_out_stall <= 1'b1;
        end else if (sink_gap > 0) begin
            i_out_stall <= 1'b1;
            sink_gap = sink_gap - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            if ($urandom_range(0, 99) < 3) sink_calm = ~sink_calm;
            sink_gap = sink_calm ? 0 : $urandom_range(0, 16);
        end
    end

    // long hold-off in the middle of a file while the source keeps offering bytes
    initial begin
        wait (bytes_sent >= 300);
        @(negedge i_clk);
        sink_hold_on = 1'b1;
        repeat (300) @(negedge i_clk);
        sink_hold_on = 1'b0;
    end

    // ---------------- watchdog: cycles with no word moving on any channel ----------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("media_chunk_demux_parser_core: mismatch");
            $finish;
        end
    end

    // ---------------- source side ----------------
    logic [7:0] file_q[$];
    bit         src_calm = 1'b0;

    task automatic send_word(input logic [7:0] b, input logic rw);
        int gap;
        if ($urandom_range(0, 99) < 3) src_calm = ~src_calm;
        gap = src_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_stream_byte = b;
        i_rewind = rw;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        send_word(8'($urandom_range(0, 255)), 1'b1);
        while (file_q.size() > 0) send_word(file_q.pop_front(), 1'b0);
        i_in_valid = 1'b0;
        i_rewind = 1'b0;
    endtask

    // wait for every result, then let the one-deep output register drain
    task automatic drain();
        while (pending > 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_file_length(input logic [31:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic put_be(input logic [31:0] value, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--) file_q.push_back(value[8*i +: 8]);
    endtask

    task automatic put_chunk_head(input logic [31:0] tag, input logic [31:0] size,
                                  input logic [31:0] stamp);
        put_be(tag, 4);
        put_be(size, 4);
        put_be(stamp, 4);
        put_be($urandom, 4);
    endtask

    task automatic put_file_header(input logic [18:0] frames, input t_break brk);
        logic [7:0] body[64];
        int k;
        for (int p = 16; p < 80; p++) body[p-16] = 8'($urandom_range(0, 255));
        for (int p = 16; p < 48; p++) body[p-16] = HDR_IMAGE[255 - 8*(p-16) -: 8];
        body[16] = 8'd0;
        body[17] = {5'd0, frames[18:16]};
        body[18] = frames[15:8];
        body[19] = frames[7:0];
        if (brk == BRK_HDR_FIELD) begin
            k = $urandom_range(16, 48);
            if (k == 48) body[17] = body[17] | 8'h08;
            else if (k == 32) body[16] = 8'($urandom_range(1, 255));
            else if (k < 33 || k > 35) body[k-16] = body[k-16] ^ (8'd1 << $urandom_range(0, 7));
        end
        put_chunk_head(mcdp_pkg::TAG_FILEHDR, brk == BRK_HDR_SIZE ? 32'd84 : 32'd80, $urandom);
        for (int i = 0; i < 64; i++) file_q.push_back(body[i]);
    endtask

    task automatic put_video(input logic [31:0] stamp, input int plen);
        put_chunk_head(mcdp_pkg::TAG_VIDEO, 32'(16 + plen), stamp);
        for (int i = 0; i < plen; i++) file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic put_audio(input logic [31:0] stamp, input int count, input int pad,
                             input logic [31:0] count_word);
        put_chunk_head(mcdp_pkg::TAG_AUDIO, 32'(20 + 2 * count + pad), stamp);
        put_be(count_word, 4);
        for (int i = 0; i < 2 * count + pad; i++) file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic put_unknown(input int plen);
        logic [31:0] tag;
        tag = $urandom;
        if (tag == mcdp_pkg::TAG_FILEHDR || tag == mcdp_pkg::TAG_VIDEO
                || tag == mcdp_pkg::TAG_AUDIO) tag = 32'h4a554e4b;
        put_chunk_head(tag, 32'(16 + plen), $urandom);
        for (int i = 0; i < plen; i++) file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // One container file: a file header, then video, audio and unknown chunks in random order.
    // Now and then one chunk is broken; the rest is then junk the parser ignores.
    task automatic build_file(input int nchunks, input int break_pct);
        logic [18:0] frames, next_frame;
        logic [31:0] audio_time;
        int          cnt, pad, plen, pick;
        t_break      brk;
        frames = 19'($urandom_range(1, 12));
        next_frame = '0;
        audio_time = 0;
        brk = BRK_NONE;
        if ($urandom_range(0, 99) < break_pct)
            brk = t_break'($urandom_range(BRK_HDR_FIELD, BRK_ZERO_FRAMES));
        if (brk == BRK_DUP_HDR) brk = BRK_NONE;
        if (brk == BRK_ZERO_FRAMES) frames = '0;
        else if ($urandom_range(0, 9) == 0) frames = 19'd450000;
        put_file_header(frames, brk);
        for (int c = 0; c < nchunks && brk == BRK_NONE; c++) begin
            if ($urandom_range(0, 99) < break_pct)
                brk = t_break'($urandom_range(BRK_ALIGN, BRK_OVERRUN));
            pick = $urandom_range(0, 9);
            plen = 4 * $urandom_range(1, 8);
            case (brk)
                BRK_ALIGN:     put_video(32'(next_frame), plen + $urandom_range(1, 3));
                BRK_TINY:      put_chunk_head($urandom, 32'(4 * $urandom_range(0, 3)), 32'd0);
                BRK_HUGE:      put_chunk_head(mcdp_pkg::TAG_VIDEO, 32'd65540, 32'(next_frame));
                BRK_VID_TIME:  put_video(32'(next_frame) + $urandom_range(1, 3), plen);
                BRK_AUD_TIME:  put_audio(audio_time + 1, 2, 0, 32'd2);
                BRK_AUD_COUNT: put_audio(audio_time, 2, 0,
                                         $urandom_range(0, 1) ? 32'd3 : 32'd8193);
                BRK_DUP_HDR:   put_file_header(frames, BRK_NONE);
                BRK_VID_BIG:   put_chunk_head(mcdp_pkg::TAG_VIDEO, 32'd32788, 32'(next_frame));
                BRK_OVERRUN:   put_chunk_head(mcdp_pkg::TAG_AUDIO, 32'd20000, audio_time);
                default: begin
                    if (pick < 5 && next_frame < frames) begin
                        put_video(32'(next_frame), plen);
                        next_frame++;
                    end else if (pick < 8) begin
                        cnt = $urandom_range(0, 6);
                        pad = 2 * $urandom_range(0, 3);
                        if ((cnt * 2 + pad) % 4 != 0) pad += 2;
                        put_audio(audio_time, cnt, pad, 32'(cnt));
                        audio_time += 32'(cnt);
                    end else begin
                        put_unknown(4 * $urandom_range(0, 4));
                    end
                end
            endcase
        end
        if (brk != BRK_NONE)
            repeat ($urandom_range(0, 8)) file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int len;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // file_length still at its reset value of zero: the first chunk overruns
        put_file_header(19'd3, BRK_NONE);
        send_file();
        drain();
        write_file_length(32'hffff_ffff);

        // directed file: header, frame 0, audio with padding, empty unknown, empty audio, frame 1, duplicate header
        put_file_header(19'd2, BRK_NONE);
        put_video(32'd0, 4);
        put_audio(32'd0, 1, 2, 32'd1);
        put_unknown(0);
        put_audio(32'd1, 0, 0, 32'd0);
        put_video(32'd1, 8);
        put_file_header(19'd2, BRK_NONE);
        send_file();
        drain();

        // random files; file_length set between files while idle
        while (bytes_sent < 700) begin
            build_file($urandom_range(2, 10), 12);
            len = file_q.size();
            case ($urandom_range(0, 5))
                0:       write_file_length(32'hffff_ffff);
                1:       write_file_length(32'(len - 4 * $urandom_range(0, 8)));
                2:       write_file_length($urandom);
                default: write_file_length(32'(len));
            endcase
            send_file();
            drain();
        end
        write_file_length(32'd0);
        build_file(2, 0);
        send_file();
        drain();

        if (fail_count == 0)
            $display("media_chunk_demux_parser_core: match");
        else
            $display("media_chunk_demux_parser_core: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
